[rtl/gkg_pkg.sv]
// Shared types and constants for the Gaussian kernel generator.
package gkg_pkg;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int SERIES_TERMS = 13;
    localparam logic [4:0] EXP_CUTOFF = 5'd17;

    typedef struct packed {
        logic start;
        logic [5:0] d2;
        logic [15:0] sig;
    } gkg_exp_req_t;

    typedef struct packed {
        logic done;
        logic [15:0] g;
    } gkg_exp_rsp_t;
endpackage

[rtl/gaussian_kernel_generator_core.sv]
// Top level of the Gaussian kernel generator: sequencer, exp series, normalization.
// Usage: one command item on s_axis (rows, cols, diameter, sigma, weight) makes
// rows*cols coefficient items on m_axis in row-major order, tlast on the final one.
// s_axis_tready is high only while the block is idle; one command is worked at a time.
// Every division runs on one shared 64-bit restoring divider. A cell inside the
// cutoff costs one exponent division, n+1 range reduction steps (n up to 16) and
// 13 series divisions. A cell outside the cutoff passes only through S_CELL and
// S_GFIN. Normalization then runs S_RD, S_NORM, S_QDIV and S_OUT for each cell.
// Output waits in a register: when the receiver stalls, the block holds.
// rows or cols of zero give no output. Reset returns the sequencer to idle;
// the scratch buffer is only read after being written within a command.
module gaussian_kernel_generator_core import gkg_pkg::*;
#(
    parameter int MAX_SIZE = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rows[3:0], cols[7:4], diameter[23:8], sigma[39:24], weight[55:40]
    input  logic [55:0] s_axis_tdata,
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    // coefficient[23:0], row_index[26:24], col_index[29:27], pad to 32
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam logic [3:0] MAXS = 4'(MAX_SIZE);

    localparam logic [3:0] S_IDLE = 4'd0, S_CELL = 4'd1, S_XDIV = 4'd2,
        S_NRED = 4'd3, S_SER = 4'd4, S_KDIV = 4'd5, S_GFIN = 4'd6,
        S_NORM = 4'd7, S_QDIV = 4'd8, S_OUT = 4'd9, S_SUMCHK = 4'd10,
        S_RD = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  rows_reg, rows_next, cols_reg, cols_next;
    logic [15:0] dia_reg, dia_next, sig_reg, sig_next;
    logic        wneg_reg, wneg_next;
    logic [15:0] wmag_reg, wmag_next;
    logic [2:0]  i_reg, i_next, j_reg, j_next;
    logic [63:0] x_reg, x_next;
    logic [4:0]  n_reg, n_next;
    logic [63:0] t_reg, t_next, term_reg, term_next, e_reg, e_next;
    logic [3:0]  k_reg, k_next;
    logic [22:0] sum_reg, sum_next;
    logic        mvalid_reg, mvalid_next;
    logic [31:0] mdata_reg, mdata_next;
    logic        mlast_reg, mlast_next;
    logic [15:0] cell_mem [1 << (2 * IW)];
    logic        cell_we;
    logic [15:0] cell_wd;
    logic [15:0] cell_rd_reg;
    logic [IW*2-1:0] addr;

    logic        div_start;
    logic [63:0] div_a;
    logic [39:0] div_b;
    logic        div_done;
    logic [63:0] div_q;

    gkg_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    logic signed [4:0] di, dj;
    logic [5:0]  d2;
    logic [31:0] dia2;
    logic [64:0] prod;
    logic [63:0] g_full;
    logic [23:0] qsat;
    logic [3:0]  rin, cin;
    logic [15:0] sin;

    assign addr = {i_reg[IW-1:0], j_reg[IW-1:0]};

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[addr] <= cell_wd;
        cell_rd_reg <= cell_mem[addr];
    end

    always_comb
    begin
        state_next = state_reg;
        rows_next = rows_reg; cols_next = cols_reg;
        dia_next = dia_reg; sig_next = sig_reg;
        wneg_next = wneg_reg; wmag_next = wmag_reg;
        i_next = i_reg; j_next = j_reg;
        x_next = x_reg; n_next = n_reg; t_next = t_reg;
        term_next = term_reg; e_next = e_reg; k_next = k_reg;
        sum_next = sum_reg;
        mvalid_next = mvalid_reg; mdata_next = mdata_reg; mlast_next = mlast_reg;
        cell_we = 1'b0; cell_wd = 16'd0;
        div_start = 1'b0; div_a = '0; div_b = '0;
        rin = s_axis_tdata[3:0];
        cin = s_axis_tdata[7:4];
        sin = s_axis_tdata[39:24];
        di = 5'($signed({2'b0, i_reg})) - 5'($signed({1'b0, rows_reg[3:1]}));
        dj = 5'($signed({2'b0, j_reg})) - 5'($signed({1'b0, cols_reg[3:1]}));
        d2 = 6'(10'(di) * 10'(di)) + 6'(10'(dj) * 10'(dj));
        dia2 = 32'(dia_reg) * 32'(dia_reg);
        prod = 65'(term_reg[32:0]) * 65'(t_reg[31:0]);
        g_full = ((e_reg >> n_reg) + 64'd32768) >> 16;
        qsat = (div_q > 64'd8388608) ? 24'h800000 : div_q[23:0];
        if (m_axis_tready)
            mvalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    rows_next = (rin > MAXS) ? MAXS : rin;
                    cols_next = (cin > MAXS) ? MAXS : cin;
                    dia_next = s_axis_tdata[23:8];
                    sig_next = (sin == 16'd0) ? 16'd1 : sin;
                    wneg_next = s_axis_tdata[55];
                    wmag_next = s_axis_tdata[55] ? 16'(17'h10000 - 17'(s_axis_tdata[55:40]))
                                                 : s_axis_tdata[55:40];
                    i_next = '0; j_next = '0; sum_next = '0;
                    if (rin != 4'd0 && cin != 4'd0)
                        state_next = S_CELL;
                end
            end
            S_CELL:
            begin
                if (dia_reg != 16'd0 && (48'(d2) << 16) < 48'(dia2))
                begin
                    div_start = 1'b1;
                    div_a = 64'(d2) << 45;
                    div_b = 40'(32'(sig_reg) * 32'(sig_reg));
                    state_next = S_XDIV;
                end
                else
                begin
                    cell_we = 1'b1;
                    state_next = S_GFIN;
                end
            end
            S_XDIV:
            begin
                if (div_done)
                begin
                    x_next = div_q;
                    n_next = '0;
                    state_next = S_NRED;
                end
            end
            S_NRED:
            begin
                if (x_reg >= 64'(LN2_Q32) && n_reg < EXP_CUTOFF)
                begin
                    x_next = x_reg - 64'(LN2_Q32);
                    n_next = n_reg + 5'd1;
                end
                else if (n_reg >= EXP_CUTOFF)
                begin
                    cell_we = 1'b1;
                    state_next = S_GFIN;
                end
                else
                begin
                    t_next = x_reg;
                    term_next = 64'h1_0000_0000;
                    e_next = 64'h1_0000_0000;
                    k_next = 4'd1;
                    state_next = S_SER;
                end
            end
            S_SER:
            begin
                div_start = 1'b1;
                div_a = 64'(prod[64:32]);
                div_b = 40'(k_reg);
                state_next = S_KDIV;
            end
            S_KDIV:
            begin
                if (div_done)
                begin
                    term_next = div_q;
                    e_next = k_reg[0] ? e_reg - div_q : e_reg + div_q;
                    if (k_reg == 4'(SERIES_TERMS))
                        state_next = S_SUMCHK;
                    else
                    begin
                        k_next = k_reg + 4'd1;
                        state_next = S_SER;
                    end
                end
            end
            S_SUMCHK:
            begin
                cell_we = 1'b1;
                cell_wd = (g_full > 64'd65535) ? 16'hFFFF : g_full[15:0];
                sum_next = sum_reg + 23'(cell_wd);
                state_next = S_GFIN;
            end
            S_GFIN:
            begin
                if (j_reg == 3'(cols_reg - 4'd1))
                begin
                    j_next = '0;
                    if (i_reg == 3'(rows_reg - 4'd1))
                    begin
                        i_next = '0;
                        state_next = S_RD;
                    end
                    else
                    begin
                        i_next = i_reg + 3'd1;
                        state_next = S_CELL;
                    end
                end
                else
                begin
                    j_next = j_reg + 3'd1;
                    state_next = S_CELL;
                end
            end
            S_RD:
            begin
                state_next = S_NORM;
            end
            S_NORM:
            begin
                div_start = 1'b1;
                div_a = 64'(40'(cell_rd_reg) * 40'(wmag_reg)) * 64'd256
                      + 64'(sum_reg[22:1]);
                div_b = 40'(sum_reg);
                state_next = S_QDIV;
            end
            S_QDIV:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    mvalid_next = 1'b1;
                    if (dia_reg == 16'd0 || sum_reg == 23'd0)
                        mdata_next[23:0] = 24'd0;
                    else if (wneg_reg)
                        mdata_next[23:0] = 24'(25'h0 - 25'(qsat));
                    else
                        mdata_next[23:0] = (qsat == 24'h800000) ? 24'h7FFFFF : qsat;
                    mdata_next[31:24] = {2'b00, j_reg, i_reg};
                    mlast_next = (i_reg == 3'(rows_reg - 4'd1))
                        && (j_reg == 3'(cols_reg - 4'd1));
                    if (j_reg == 3'(cols_reg - 4'd1))
                    begin
                        j_next = '0;
                        if (i_reg == 3'(rows_reg - 4'd1))
                        begin
                            i_next = '0;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + 3'd1;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 3'd1;
                        state_next = S_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mvalid_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mvalid_reg <= mvalid_next;
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg <= rows_next; cols_reg <= cols_next;
        dia_reg <= dia_next; sig_reg <= sig_next;
        wneg_reg <= wneg_next; wmag_reg <= wmag_next;
        x_reg <= x_next; n_reg <= n_next; t_reg <= t_next;
        term_reg <= term_next; e_reg <= e_next; k_reg <= k_next;
        sum_reg <= sum_next;
        mdata_reg <= mdata_next; mlast_reg <= mlast_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata = mdata_reg;
    assign m_axis_tlast = mlast_reg;

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output dropped under stall");
endmodule

[rtl/gkg_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
module gkg_divider import gkg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [39:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] q_reg, q_next;
    logic [40:0] r_reg, r_next;
    logic [39:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [40:0] shifted;
    logic [41:0] diff;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted = {r_reg[39:0], q_reg[63]};
        diff = {1'b0, shifted} - {2'b00, d_reg};
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[41])
            begin
                r_next = diff[40:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule
